[hw/rtl/cpu_compare_incdec_jump_unit_defines.svh]
// Assertion macros shared by the RTL of the compare, inc/dec and jump unit.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef CPU_COMPARE_INCDEC_JUMP_UNIT_DEFINES_SVH
`define CPU_COMPARE_INCDEC_JUMP_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define CCIJ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define CCIJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define CCIJ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CCIJ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/ccij_pkg.sv]
`default_nettype none

package ccij_pkg;

    // Depth of the queue between the decode front and the execute back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = QPTR_W + 1;

    // High byte of every stack address.
    localparam logic [7:0] STACK_PAGE_HI = 8'h01;

    // Flag positions in the six-bit status word: N V D I Z C.
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 4;
    localparam int unsigned FLAG_N = 5;

    localparam logic [5:0] MASK_D = 6'b00_1000;
    localparam logic [5:0] MASK_I = 6'b00_0100;
    localparam logic [5:0] MASK_V = 6'b01_0000;

    // Instruction codes as they arrive on the input.
    typedef enum logic [3:0] {
        ACT_CLD    = 4'd0,
        ACT_CLI    = 4'd1,
        ACT_CLV    = 4'd2,
        ACT_CMP    = 4'd3,
        ACT_CPX    = 4'd4,
        ACT_CPY    = 4'd5,
        ACT_DEC    = 4'd6,
        ACT_DEX    = 4'd7,
        ACT_DEY    = 4'd8,
        ACT_EOR    = 4'd9,
        ACT_INC    = 4'd10,
        ACT_INX    = 4'd11,
        ACT_INY    = 4'd12,
        ACT_JMP    = 4'd13,
        ACT_JMPIND = 4'd14,
        ACT_JSR    = 4'd15
    } t_action;

    // Operation classes seen by the execute stage.
    typedef enum logic [2:0] {
        CLS_CLR = 3'd0,
        CLS_CMP = 3'd1,
        CLS_RMW = 3'd2,
        CLS_IDX = 3'd3,
        CLS_EOR = 3'd4,
        CLS_JMP = 3'd5,
        CLS_JSR = 3'd6
    } t_op_class;

    typedef enum logic [1:0] {
        REG_A = 2'd0,
        REG_X = 2'd1,
        REG_Y = 2'd2
    } t_reg_sel;

    // One decoded instruction as it sits in the queue.
    typedef struct packed {
        t_op_class   op_class;
        t_reg_sel    reg_sel;
        logic        decrement;
        logic [5:0]  clear_mask;
        logic [1:0]  pc_step;
        logic [7:0]  operand;
        logic [15:0] address;
    } t_op;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Replaces N and Z from an 8-bit result, keeps the other flags.
    function automatic logic [5:0] set_nz(input logic [5:0] flags, input logic [7:0] value);
        logic [5:0] f;
        f         = flags;
        f[FLAG_Z] = (value == 8'd0);
        f[FLAG_N] = value[7];
        return f;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cpu_compare_incdec_jump_unit.sv]
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  action, operand, operand_address, indirect bytes, length
// result    out        o_valid / i_ready  write enable/address/data, flags, PC, last flag
//
// An accepted instruction is decoded the same cycle and queued (four entries).
// The execute stage retires one result per cycle unless the output stalls or the queue
// is empty; JSR emits two results, its two stack writes. Each result is registered.
// The output register lets a new result load in the cycle the old one is taken.
// Reset (synchronous, active low) zeroes A, X, Y, S, PC and flags and empties the queue.
`default_nettype none
`include "cpu_compare_incdec_jump_unit_defines.svh"

module cpu_compare_incdec_jump_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [3:0]  i_action,
    input  wire logic [7:0]  i_operand,
    input  wire logic [15:0] i_operand_address,
    input  wire logic [7:0]  i_indirect_low,
    input  wire logic [7:0]  i_indirect_high,
    input  wire logic [1:0]  i_instr_length,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_write_enable,
    output logic [15:0]      o_write_address,
    output logic [7:0]       o_write_data,
    output logic [5:0]       o_status_flags,
    output logic [15:0]      o_program_counter,
    output logic             o_last_result
);
    import ccij_pkg::*;

    t_q_status w_q_status;
    t_op       w_front_op;
    t_op       w_head_op;
    logic      w_push;
    logic      w_pop;

    // Decode front.
    ccij_front u_front (
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_action          (i_action),
        .i_operand         (i_operand),
        .i_operand_address (i_operand_address),
        .i_indirect_low    (i_indirect_low),
        .i_indirect_high   (i_indirect_high),
        .i_instr_length    (i_instr_length),
        .i_q_status        (w_q_status),
        .o_push            (w_push),
        .o_op              (w_front_op)
    );

    // Instruction queue between the two sides.
    ccij_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_op     (w_front_op),
        .i_pop    (w_pop),
        .o_op     (w_head_op),
        .o_status (w_q_status)
    );

    // Execute back.
    ccij_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (w_head_op),
        .i_q_status        (w_q_status),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_write_enable    (o_write_enable),
        .o_write_address   (o_write_address),
        .o_write_data      (o_write_data),
        .o_status_flags    (o_status_flags),
        .o_program_counter (o_program_counter),
        .o_last_result     (o_last_result)
    );

    // Only the first half of a subroutine call is not final, and it always writes.
    `CCIJ_ASSERT_IMP(a_first_half_writes, i_clk, i_rst_n, o_valid && !o_last_result, o_write_enable)

    // The second half of a subroutine call follows its first half directly.
    `CCIJ_ASSERT_NEXT(a_second_half_follows, i_clk, i_rst_n, o_valid && i_ready && !o_last_result, o_valid && o_last_result && o_write_enable)

    // A result without a write carries zero address and data.
    `CCIJ_ASSERT_IMP(a_idle_write_zero, i_clk, i_rst_n, o_valid && !o_write_enable, o_write_address == 16'd0 && o_write_data == 8'd0)

endmodule

`default_nettype wire

[hw/rtl/ccij_front.sv]
`default_nettype none

module ccij_front (
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [3:0]          i_action,
    input  wire logic [7:0]          i_operand,
    input  wire logic [15:0]         i_operand_address,
    input  wire logic [7:0]          i_indirect_low,
    input  wire logic [7:0]          i_indirect_high,
    input  wire logic [1:0]          i_instr_length,
    input  wire ccij_pkg::t_q_status i_q_status,
    output logic                     o_push,
    output ccij_pkg::t_op            o_op
);
    import ccij_pkg::*;

    // A transaction is taken whenever the queue has room.
    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // Classify the instruction and pick the fields the execute stage needs.
    always_comb begin
        o_op            = '0;
        o_op.op_class   = CLS_CLR;
        o_op.reg_sel    = REG_A;
        o_op.decrement  = 1'b0;
        o_op.clear_mask = '0;
        o_op.pc_step    = 2'd1;
        o_op.operand    = i_operand;
        o_op.address    = i_operand_address;
        unique case (t_action'(i_action))
            ACT_CLD: begin
                o_op.clear_mask = MASK_D;
            end
            ACT_CLI: begin
                o_op.clear_mask = MASK_I;
            end
            ACT_CLV: begin
                o_op.clear_mask = MASK_V;
            end
            ACT_CMP: begin
                o_op.op_class = CLS_CMP;
                o_op.pc_step  = i_instr_length;
            end
            ACT_CPX: begin
                o_op.op_class = CLS_CMP;
                o_op.reg_sel  = REG_X;
                o_op.pc_step  = i_instr_length;
            end
            ACT_CPY: begin
                o_op.op_class = CLS_CMP;
                o_op.reg_sel  = REG_Y;
                o_op.pc_step  = i_instr_length;
            end
            ACT_DEC: begin
                o_op.op_class  = CLS_RMW;
                o_op.decrement = 1'b1;
                o_op.pc_step   = i_instr_length;
            end
            ACT_INC: begin
                o_op.op_class = CLS_RMW;
                o_op.pc_step  = i_instr_length;
            end
            ACT_DEX: begin
                o_op.op_class  = CLS_IDX;
                o_op.reg_sel   = REG_X;
                o_op.decrement = 1'b1;
            end
            ACT_DEY: begin
                o_op.op_class  = CLS_IDX;
                o_op.reg_sel   = REG_Y;
                o_op.decrement = 1'b1;
            end
            ACT_INX: begin
                o_op.op_class = CLS_IDX;
                o_op.reg_sel  = REG_X;
            end
            ACT_INY: begin
                o_op.op_class = CLS_IDX;
                o_op.reg_sel  = REG_Y;
            end
            ACT_EOR: begin
                o_op.op_class = CLS_EOR;
                o_op.pc_step  = i_instr_length;
            end
            ACT_JMP: begin
                o_op.op_class = CLS_JMP;
            end
            ACT_JMPIND: begin
                o_op.op_class = CLS_JMP;
                o_op.address  = {i_indirect_high, i_indirect_low};
            end
            ACT_JSR: begin
                // The return address is the PC plus two.
                o_op.op_class = CLS_JSR;
                o_op.pc_step  = 2'd2;
            end
            default: begin
                o_op.op_class = CLS_CLR;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/ccij_queue.sv]
`default_nettype none

module ccij_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ccij_pkg::t_op  i_op,
    input  wire logic           i_pop,
    output ccij_pkg::t_op       o_op,
    output ccij_pkg::t_q_status o_status
);
    import ccij_pkg::*;

    t_op               r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;

    // The head entry is presented to the execute stage directly.
    assign o_op = r_entries[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_entries[r_wr_ptr] <= i_op;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ccij_back.sv]
`default_nettype none

module ccij_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ccij_pkg::t_op       i_op,
    input  wire ccij_pkg::t_q_status i_q_status,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_write_enable,
    output logic [15:0]              o_write_address,
    output logic [7:0]               o_write_data,
    output logic [5:0]               o_status_flags,
    output logic [15:0]              o_program_counter,
    output logic                     o_last_result
);
    import ccij_pkg::*;

    // Architectural state.
    logic [7:0]  r_a, n_a;
    logic [7:0]  r_x, n_x;
    logic [7:0]  r_y, n_y;
    logic [7:0]  r_s, n_s;
    logic [15:0] r_pc, n_pc;
    logic [5:0]  r_flags, n_flags;
    logic        r_jsr_second, n_jsr_second;

    // Output register.
    logic        r_out_valid;
    logic        r_we, n_we;
    logic [15:0] r_waddr, n_waddr;
    logic [7:0]  r_wdata, n_wdata;
    logic [5:0]  r_flags_out;
    logic [15:0] r_pc_out, n_pc_out;
    logic        r_last, n_last;

    logic        w_load;
    logic [7:0]  w_src;
    logic [7:0]  w_incdec_in;
    logic [7:0]  w_incdec;
    logic [8:0]  w_diff;
    logic [15:0] w_pc_sum;
    logic [7:0]  w_eor;

    // A result is produced when an instruction waits and the output register frees up.
    assign w_load = !i_q_status.empty && (!r_out_valid || i_ready);
    assign o_pop  = w_load && !(i_op.op_class == CLS_JSR && !r_jsr_second);

    // Shared datapath pieces.
    always_comb begin
        case (i_op.reg_sel)
            REG_X:   w_src = r_x;
            REG_Y:   w_src = r_y;
            default: w_src = r_a;
        endcase
    end

    assign w_incdec_in = (i_op.op_class == CLS_RMW) ? i_op.operand : w_src;
    assign w_incdec    = i_op.decrement ? (w_incdec_in - 8'd1) : (w_incdec_in + 8'd1);
    assign w_diff      = {1'b0, w_src} - {1'b0, i_op.operand};
    assign w_pc_sum    = r_pc + {14'd0, i_op.pc_step};
    assign w_eor       = r_a ^ i_op.operand;

    // Execute the head instruction.
    always_comb begin
        n_a          = r_a;
        n_x          = r_x;
        n_y          = r_y;
        n_s          = r_s;
        n_pc         = r_pc;
        n_flags      = r_flags;
        n_jsr_second = r_jsr_second;
        n_we         = 1'b0;
        n_waddr      = '0;
        n_wdata      = '0;
        n_last       = 1'b1;
        n_pc_out     = '0;
        unique case (i_op.op_class)
            CLS_CLR: begin
                n_flags = r_flags & ~i_op.clear_mask;
                n_pc    = w_pc_sum;
            end
            CLS_CMP: begin
                n_flags         = set_nz(r_flags, w_diff[7:0]);
                n_flags[FLAG_C] = !w_diff[8];
                n_pc            = w_pc_sum;
            end
            CLS_RMW: begin
                n_flags = set_nz(r_flags, w_incdec);
                n_pc    = w_pc_sum;
                n_we    = 1'b1;
                n_waddr = i_op.address;
                n_wdata = w_incdec;
            end
            CLS_IDX: begin
                n_flags = set_nz(r_flags, w_incdec);
                n_pc    = w_pc_sum;
                if (i_op.reg_sel == REG_X) begin
                    n_x = w_incdec;
                end else begin
                    n_y = w_incdec;
                end
            end
            CLS_EOR: begin
                n_a     = w_eor;
                n_flags = set_nz(r_flags, w_eor);
                n_pc    = w_pc_sum;
            end
            CLS_JMP: begin
                n_pc = i_op.address;
            end
            CLS_JSR: begin
                // High byte of the return address first, then the low byte.
                n_we    = 1'b1;
                n_waddr = {STACK_PAGE_HI, r_s};
                n_s     = r_s - 8'd1;
                if (!r_jsr_second) begin
                    n_wdata      = w_pc_sum[15:8];
                    n_last       = 1'b0;
                    n_jsr_second = 1'b1;
                end else begin
                    n_wdata      = w_pc_sum[7:0];
                    n_pc         = i_op.address;
                    n_jsr_second = 1'b0;
                end
            end
            default: begin
                n_pc = r_pc;
            end
        endcase
        // Both results of a subroutine call report the PC after the jump.
        n_pc_out = (i_op.op_class == CLS_JSR) ? i_op.address : n_pc;
    end

    // Architectural and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a          <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_s          <= '0;
            r_pc         <= '0;
            r_flags      <= '0;
            r_jsr_second <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_load) begin
                r_a          <= n_a;
                r_x          <= n_x;
                r_y          <= n_y;
                r_s          <= n_s;
                r_pc         <= n_pc;
                r_flags      <= n_flags;
                r_jsr_second <= n_jsr_second;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_we        <= n_we;
            r_waddr     <= n_waddr;
            r_wdata     <= n_wdata;
            r_flags_out <= n_flags;
            r_pc_out    <= n_pc_out;
            r_last      <= n_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_write_enable    = r_we;
    assign o_write_address   = r_waddr;
    assign o_write_data      = r_wdata;
    assign o_status_flags    = r_flags_out;
    assign o_program_counter = r_pc_out;
    assign o_last_result     = r_last;

endmodule

`default_nettype wire
